// File: rtl/fssa_pkg.sv
// Shared types and constants for the frame-scoped slot allocator.
package fssa_pkg;

    localparam int SLOT_DEPTH  = 256;
    localparam int FRAME_DEPTH = 64;
    localparam int NAME_BITS   = 16;

    localparam int NAME_FIELD_W = 16;
    localparam int SLOT_FIELD_W = 8;

    localparam int NAME_W   = (NAME_BITS < NAME_FIELD_W) ? NAME_BITS : NAME_FIELD_W;
    localparam int SLOT_AW  = $clog2(SLOT_DEPTH);
    localparam int FILL_W   = $clog2(SLOT_DEPTH + 1);
    localparam int FRAME_AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FCNT_W   = $clog2(FRAME_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_ENTER  = 2'd0,
        MODE_EXIT   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SLOTS_FULL = 2'd1,
        ST_FRAME_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                     mode;
        logic [NAME_FIELD_W-1:0]   name_handle;
    } req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0]   slot_index;
        logic                      was_found;
        status_t                   status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_BASE,
        S_SCAN,
        S_CMP,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_FRAME_ERR,
        RES_SLOTS_FULL,
        RES_FOUND,
        RES_NEW
    } res_code_t;

    typedef struct packed {
        logic      load;
        logic      frame_push;
        logic      frame_rd;
        logic      fcnt_dec;
        logic      fill_restore;
        logic      base_load;
        logic      slot_rd;
        logic      alloc;
        logic      idx_inc;
        logic      res_set;
        res_code_t res_code;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  frame_empty;
        logic  frame_full;
        logic  scan_more;
        logic  slots_full;
        logic  match;
        logic  out_free;
    } stat_t;

endpackage

// File: rtl/frame_scoped_slot_allocator_unit.sv
// Enter frame, no-op and no-frame errors go from decode straight to the response state;
// exit frame passes through a pop state; lookup loads the frame base, then reads and
// compares slots one by one on the slot RAM port until a hit, a miss or full slot stack.
// One word in flight: the next word is taken one cycle after the result is loaded, and
// may be taken while that result still waits on rsp_ready, which holds off the next load.
// Reset (rst_n, async, active low) zeroes fill level and frame count; memories not cleared.
module frame_scoped_slot_allocator_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fssa_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fssa_pkg::rsp_t rsp_data
);
    import fssa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fssa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fssa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // a word just taken keeps the input closed until its result is built
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input reopened right after accept");

    // failed operations report nothing but their status
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK |-> rsp_data.slot_index == '0
            && !rsp_data.was_found)
        else $error("error word carries slot data");

    // never allocate past the top of the slot stack
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !stat.slots_full)
        else $error("allocation with slot stack full");

    a_scan_framed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slot_rd || cmd.base_load |-> !stat.frame_empty)
        else $error("slot scan with no frame open");

endmodule

// File: rtl/fssa_ram.sv
// Generic simple dual-port RAM with registered read.
module fssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fssa_datapath.sv
// Datapath: counters, slot and frame-base memories, result and output registers.
module fssa_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  fssa_pkg::req_t req_data,
    input  fssa_pkg::cmd_t cmd,
    output fssa_pkg::stat_t stat,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fssa_pkg::rsp_t rsp_data
);
    import fssa_pkg::*;

    mode_t               mode_reg;
    logic [NAME_W-1:0]   name_reg;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FCNT_W-1:0]   fcnt_reg, fcnt_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                res_reg;
    rsp_t                rsp_reg;

    logic [FCNT_W-1:0]   fcnt_m1;
    logic [FILL_W-1:0]   base_rd_data;
    logic [NAME_W-1:0]   slot_rd_data;

    assign fcnt_m1 = fcnt_reg - FCNT_W'(1);

    fssa_ram #(
        .WIDTH (FILL_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (cmd.frame_push),
        .wr_addr (fcnt_reg[FRAME_AW-1:0]),
        .wr_data (fill_reg),
        .rd_en   (cmd.frame_rd),
        .rd_addr (fcnt_m1[FRAME_AW-1:0]),
        .rd_data (base_rd_data)
    );

    fssa_ram #(
        .WIDTH (NAME_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (cmd.alloc),
        .wr_addr (fill_reg[SLOT_AW-1:0]),
        .wr_data (name_reg),
        .rd_en   (cmd.slot_rd),
        .rd_addr (idx_reg[SLOT_AW-1:0]),
        .rd_data (slot_rd_data)
    );

    always_comb
    begin
        fill_next = fill_reg;
        fcnt_next = fcnt_reg;
        idx_next  = idx_reg;
        if (cmd.frame_push)
        begin
            fcnt_next = fcnt_reg + FCNT_W'(1);
        end
        if (cmd.fcnt_dec)
        begin
            fcnt_next = fcnt_m1;
        end
        if (cmd.fill_restore)
        begin
            fill_next = base_rd_data;
        end
        if (cmd.alloc)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        if (cmd.base_load)
        begin
            idx_next = base_rd_data;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + FILL_W'(1);
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            fcnt_reg      <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            fcnt_reg      <= fcnt_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req_data.mode;
            name_reg <= req_data.name_handle[NAME_W-1:0];
        end
        if (cmd.res_set)
        begin
            case (cmd.res_code)
                RES_FRAME_ERR:
                begin
                    res_reg <= '{slot_index: '0, was_found: 1'b0, status: ST_FRAME_ERR};
                end
                RES_SLOTS_FULL:
                begin
                    res_reg <= '{slot_index: '0, was_found: 1'b0, status: ST_SLOTS_FULL};
                end
                RES_FOUND:
                begin
                    res_reg <= '{slot_index: SLOT_FIELD_W'(idx_reg), was_found: 1'b1,
                                 status: ST_OK};
                end
                RES_NEW:
                begin
                    res_reg <= '{slot_index: SLOT_FIELD_W'(fill_reg), was_found: 1'b0,
                                 status: ST_OK};
                end
                default:
                begin
                    res_reg <= '{slot_index: '0, was_found: 1'b0, status: ST_OK};
                end
            endcase
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign stat.mode        = mode_reg;
    assign stat.frame_empty = (fcnt_reg == '0);
    assign stat.frame_full  = (fcnt_reg >= FCNT_W'(FRAME_DEPTH));
    assign stat.scan_more   = (idx_reg < fill_reg);
    assign stat.slots_full  = (fill_reg >= FILL_W'(SLOT_DEPTH));
    assign stat.match       = (slot_rd_data == name_reg);
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// File: rtl/fssa_ctrl.sv
// Controller state machine: sequences frame operations and the slot scan.
module fssa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  fssa_pkg::stat_t stat,
    output fssa_pkg::cmd_t  cmd
);
    import fssa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_EXIT:   state_next = stat.frame_empty ? S_RESP : S_POP;
                    MODE_LOOKUP: state_next = stat.frame_empty ? S_RESP : S_BASE;
                    default:     state_next = S_RESP;
                endcase
            end
            S_POP:  state_next = S_RESP;
            S_BASE: state_next = S_SCAN;
            S_SCAN: state_next = stat.scan_more ? S_CMP : S_RESP;
            S_CMP:  state_next = stat.match ? S_RESP : S_SCAN;
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.res_code = RES_OK;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_ENTER:
                    begin
                        cmd.res_set = 1'b1;
                        if (stat.frame_full)
                        begin
                            cmd.res_code = RES_FRAME_ERR;
                        end
                        else
                        begin
                            cmd.frame_push = 1'b1;
                        end
                    end
                    MODE_EXIT:
                    begin
                        cmd.res_set = 1'b1;
                        if (stat.frame_empty)
                        begin
                            cmd.res_code = RES_FRAME_ERR;
                        end
                        else
                        begin
                            cmd.frame_rd = 1'b1;
                            cmd.fcnt_dec = 1'b1;
                        end
                    end
                    MODE_LOOKUP:
                    begin
                        if (stat.frame_empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_FRAME_ERR;
                        end
                        else
                        begin
                            cmd.frame_rd = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.fill_restore = 1'b1;
            end
            S_BASE:
            begin
                cmd.base_load = 1'b1;
            end
            S_SCAN:
            begin
                if (stat.scan_more)
                begin
                    cmd.slot_rd = 1'b1;
                end
                else if (stat.slots_full)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_SLOTS_FULL;
                end
                else
                begin
                    cmd.alloc    = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_NEW;
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_FOUND;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_RESP:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: tb/tb_frame_scoped_slot_allocator_unit.sv
// Self-checking testbench for the frame-scoped slot allocator.
`timescale 1ns / 100ps

module tb_frame_scoped_slot_allocator_unit;
    import fssa_pkg::*;

    class slot_alloc_checker;
        logic [NAME_W-1:0] names [SLOT_DEPTH];
        int unsigned       bases [FRAME_DEPTH];
        int unsigned       fill;
        int unsigned       frames;
        int                errors;
        rsp_t              owed_results [$];

        function new();
            fill   = 0;
            frames = 0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        // Apply one accepted word to the shadow frame stack and queue its result.
        function void note_request(req_t w);
            rsp_t              r;
            logic [NAME_W-1:0] nm;
            int unsigned       i;
            bit                hit;
            r        = '0;
            r.status = ST_OK;
            nm       = w.name_handle[NAME_W-1:0];
            hit      = 1'b0;
            case (w.mode)
                MODE_ENTER:
                    if (frames >= FRAME_DEPTH)
                        r.status = ST_FRAME_ERR;
                    else
                    begin
                        bases[frames] = fill;
                        frames++;
                    end
                MODE_EXIT:
                    if (frames == 0)
                        r.status = ST_FRAME_ERR;
                    else
                    begin
                        frames--;
                        fill = bases[frames];
                    end
                MODE_LOOKUP:
                    if (frames == 0)
                        r.status = ST_FRAME_ERR;
                    else
                    begin
                        // only the top frame is visible, lowest slot wins
                        for (i = bases[frames-1]; i < fill && !hit; i++)
                        begin
                            if (names[i] == nm)
                            begin
                                hit          = 1'b1;
                                r.slot_index = i[SLOT_FIELD_W-1:0];
                                r.was_found  = 1'b1;
                            end
                        end
                        if (!hit)
                        begin
                            if (fill >= SLOT_DEPTH)
                                r.status = ST_SLOTS_FULL;
                            else
                            begin
                                names[fill]  = nm;
                                r.slot_index = fill[SLOT_FIELD_W-1:0];
                                fill++;
                            end
                        end
                    end
                default:
                    ;
            endcase
            owed_results.push_back(r);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result word with none owed: slot %0d found %0d status %0d",
                                 got.slot_index, got.was_found, got.status));
                return;
            end
            want = owed_results.pop_front();
            if (got.slot_index !== want.slot_index)
                report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
            if (got.was_found !== want.was_found)
                report($sformatf("was_found %0d, want %0d", got.was_found, want.was_found));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    logic              calm = 1'b0;
    int unsigned       words_sent = 0;
    logic [15:0]       name_pool [8];
    slot_alloc_checker chk;

    frame_scoped_slot_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(99) >= 18);

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            chk.check_result(rsp_data);

    task automatic send_word(mode_t m, logic [NAME_FIELD_W-1:0] nm);
        req_t w;
        w.mode        = m;
        w.name_handle = nm;
        while (!calm && $urandom_range(99) < 18)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        calm      <= (words_sent >= 900 && words_sent < 1100);
        req_valid <= 1'b1;
        req_data  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        chk.note_request(w);
        words_sent++;
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic drain();
        req_valid <= 1'b0;
        while (chk.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly names already in the top frame or a small pool, so hits are common.
    function automatic logic [NAME_FIELD_W-1:0] pick_name();
        int unsigned lo;
        lo = (chk.frames != 0) ? chk.bases[chk.frames-1] : 0;
        if (chk.frames != 0 && chk.fill > lo && $urandom_range(99) < 45)
            return chk.names[$urandom_range(chk.fill - 1, lo)];
        if ($urandom_range(99) < 40)
            return name_pool[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    task automatic walk(int unsigned upto);
        int unsigned r;
        mode_t       m;
        while (words_sent < upto)
        begin
            r = $urandom_range(99);
            if (r < 4)
                m = MODE_NOP;
            else if (chk.frames == 0)
            begin
                if (r < 70)
                    m = MODE_ENTER;
                else if (r < 85)
                    m = MODE_EXIT;
                else
                    m = MODE_LOOKUP;
            end
            else if (chk.fill > 40 || chk.frames > 8)
            begin
                if (r < 45)
                    m = MODE_EXIT;
                else if (r < 50)
                    m = MODE_ENTER;
                else
                    m = MODE_LOOKUP;
            end
            else
            begin
                if (r < 20)
                    m = MODE_ENTER;
                else if (r < 32)
                    m = MODE_EXIT;
                else
                    m = MODE_LOOKUP;
            end
            if (m == MODE_LOOKUP)
                send_word(m, pick_name());
            else
                send_word(m, 16'($urandom));
            if ($urandom_range(199) == 0)
                drain();
            if ($urandom_range(99) == 0)
                name_pool[$urandom_range(7)] = 16'($urandom);
        end
    endtask

    initial
    begin
        chk = new();
        foreach (name_pool[k])
            name_pool[k] = 16'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // errors with no frame open, then nested frames and scoping
        send_word(MODE_LOOKUP, 16'h1234);
        send_word(MODE_EXIT,   16'h0000);
        send_word(MODE_NOP,    16'hFFFF);
        send_word(MODE_ENTER,  16'h0000);
        send_word(MODE_LOOKUP, 16'h0000);
        send_word(MODE_LOOKUP, 16'hFFFF);
        send_word(MODE_LOOKUP, 16'h0000);
        send_word(MODE_LOOKUP, 16'hFFFF);
        send_word(MODE_ENTER,  16'hFFFF);
        send_word(MODE_LOOKUP, 16'h0000);
        send_word(MODE_LOOKUP, 16'hA5A5);
        send_word(MODE_LOOKUP, 16'h5A5A);
        send_word(MODE_LOOKUP, 16'h5A5A);
        send_word(MODE_NOP,    16'h0000);
        send_word(MODE_EXIT,   16'hFFFF);
        send_word(MODE_LOOKUP, 16'hA5A5);
        send_word(MODE_EXIT,   16'h0000);
        send_word(MODE_EXIT,   16'h0000);
        send_word(MODE_ENTER,  16'h0000);
        send_word(MODE_EXIT,   16'h0000);

        walk(600);
        drain();

        // Fill both stacks to the brim with small frames so scans stay short.
        while (chk.frames != 0)
            send_word(MODE_EXIT, 16'($urandom));
        while (chk.frames < FRAME_DEPTH)
        begin
            send_word(MODE_ENTER, 16'($urandom));
            while (chk.fill < (SLOT_DEPTH / FRAME_DEPTH) * chk.frames)
                send_word(MODE_LOOKUP, ($urandom_range(9) == 0) ? pick_name() : 16'($urandom));
        end
        send_word(MODE_ENTER, 16'hFFFF);
        send_word(MODE_LOOKUP, 16'($urandom));
        repeat (6) send_word(MODE_LOOKUP, pick_name());
        while (chk.frames != 0)
        begin
            if ($urandom_range(99) < 30)
                send_word(MODE_LOOKUP, pick_name());
            else
                send_word(MODE_EXIT, 16'($urandom));
        end
        send_word(MODE_EXIT, 16'($urandom));
        drain();

        walk(1370);

        drain();
        repeat (40) @(posedge clk);
        if (chk.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fssa_pkg.sv
rtl/fssa_ram.sv
rtl/fssa_datapath.sv
rtl/fssa_ctrl.sv
rtl/frame_scoped_slot_allocator_unit.sv
tb/tb_frame_scoped_slot_allocator_unit.sv
